// ----- rtl/core/edra_pkg.sv -----
// Shared types and constants of the encoder detent ramp accumulator.
// No dependencies; imported by encoder_detent_ramp_accumulator.
`default_nettype none

package edra_pkg;

  // Fixed geometry of the block
  localparam int unsigned SlotCount       = 4;
  localparam int unsigned SlotBits        = 2;
  localparam int unsigned CountsPerDetent = 4;
  localparam int unsigned CpdShift        = $clog2(CountsPerDetent);
  localparam int unsigned ValueBits       = 10;
  localparam int unsigned StepBits        = 8;
  localparam int unsigned WindowBits      = 16;
  localparam int unsigned TimeBits        = 32;
  localparam int unsigned CountBits       = 8;
  // Sum of residual and count change, and detent count taken from it
  localparam int unsigned TotalBits       = CountBits + 1;
  // Largest detent magnitude is 2^(CountBits-1) / CountsPerDetent
  localparam int unsigned DetMagBits      = CountBits - CpdShift;
  // Running value during the ramp: value plus up to 32 steps of 255
  localparam int unsigned AccBits         = 16;

  localparam int unsigned AddrBits        = 5;
  localparam int unsigned DataBits        = 32;

  // Reset values of the configuration registers
  localparam logic                  RampEnableReset = 1'b1;
  localparam logic [WindowBits-1:0] RampWindowReset = 16'd75;
  localparam logic [StepBits-1:0]   RampLimitReset  = 8'd8;
  localparam logic [ValueBits-1:0]  SlotMaxReset [SlotCount] = '{
    10'd100, 10'd360, 10'd100, 10'd100
  };
  localparam logic [SlotBits:0]     NoSlot          = 3'd4;

  // Register map, one 32-bit word per register
  typedef enum logic [2:0] {
    RegRampEnable = 3'd0,
    RegRampWindow = 3'd1,
    RegRampLimit  = 3'd2,
    RegSlot0Max   = 3'd3,
    RegSlot1Max   = 3'd4,
    RegSlot2Max   = 3'd5,
    RegSlot3Max   = 3'd6
  } reg_idx_e;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StPrep = 4'b0010,
    StRamp = 4'b0100,
    StDone = 4'b1000
  } state_e;

  typedef struct packed {
    logic [SlotBits-1:0]         encoder_slot;
    logic signed [CountBits-1:0] count_change;
    logic [TimeBits-1:0]         now_ms;
    logic                        drag_active;
    logic [ValueBits-1:0]        drag_value;
  } in_word_t;

  typedef struct packed {
    logic [SlotBits-1:0]  out_slot;
    logic [ValueBits-1:0] slot_value_out;
    logic                 value_changed;
  } out_word_t;

endpackage

`default_nettype wire

// ----- rtl/core/encoder_detent_ramp_accumulator.sv -----
// Rotary encoder detent accumulator with acceleration ramp, four value slots.
// Depends on edra_pkg (types, register map, reset values).
//
// Usage:
// - Input words (slot, signed count change, ms timestamp, drag override)
//   arrive on in_valid_i/in_ready_o; one result word per input leaves on
//   out_valid_o/out_ready_i from an output register.
// - in_ready_o is high only while the sequencer is idle. After acceptance
//   the word passes the setup state StPrep, the ramp loop StRamp (|detents|
//   is 0..32) and the clamp state StDone, which loads the output register;
//   drag words, words without detents and words with the ramp off skip the
//   loop. A new word is taken only after the last one has left StDone.
//   The ramp loop runs a single adder over the detents, one per cycle.
// - The result appears on out_valid_o in the cycle after StDone loads it.
//   The next word may be accepted while that result waits; if the receiver
//   still stalls when the following result is ready, the sequencer holds it
//   in the clamp cycle until the output register frees up.
// - Configuration goes through APB (pready always high, zero wait states);
//   the user must write it only while idle; the block does not enforce it.
// - Reset clears all slot values and residual counts, sets the ramp step to
//   one, forgets the last ramped slot and loads the register defaults.
`default_nettype none

module encoder_detent_ramp_accumulator (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // input channel
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  edra_pkg::in_word_t          in_word_i,
  // result channel
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output edra_pkg::out_word_t               out_word_o,
  // configuration port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [edra_pkg::AddrBits-1:0]     paddr,
  input  wire  [edra_pkg::DataBits-1:0]     pwdata,
  output logic [edra_pkg::DataBits-1:0]     prdata,
  output logic                              pready
);
  import edra_pkg::*;

  // configuration registers
  logic                  ramp_en_q;
  logic [WindowBits-1:0] window_q;
  logic [StepBits-1:0]   limit_q;
  logic [ValueBits-1:0]  slot_max_q [SlotCount];

  // slot state
  logic [ValueBits-1:0]  value_q [SlotCount];
  logic [CpdShift-1:0]   resid_q [SlotCount];
  logic [StepBits-1:0]   step_q, step_d;
  logic [SlotBits:0]     last_slot_q, last_slot_d;
  logic [TimeBits-1:0]   last_time_q, last_time_d;

  // sequencer and working registers
  state_e                    state_q, state_d;
  in_word_t                  item_q, item_d;
  logic signed [AccBits-1:0] acc_q, acc_d;
  logic [DetMagBits-1:0]     cnt_q, cnt_d;
  logic                      neg_q, neg_d;
  logic                      chg_q, chg_d;
  logic [ValueBits-1:0]      maxv_q, maxv_d;

  logic                      out_valid_q, out_valid_d;
  out_word_t                 out_word_q, out_word_d;

  // slot state write strobes
  logic                      value_we, resid_we;
  logic [ValueBits-1:0]      value_wdata;
  logic [CpdShift-1:0]       resid_wdata;

  // setup-cycle arithmetic
  logic [SlotBits-1:0]          slot;
  logic [ValueBits-1:0]         cur_value;
  logic [ValueBits-1:0]         slot_max;
  logic [ValueBits-1:0]         drag_clamped;
  logic signed [TotalBits-1:0]  total;
  logic signed [TotalBits-1:0]  detents;
  logic [TotalBits-1:0]         det_mag;
  logic [TimeBits-1:0]          gap;
  logic                         restart;
  logic signed [AccBits-1:0]    step_ext;
  logic signed [AccBits-1:0]    maxv_ext;

  // configuration write strobe
  logic                         cfg_we;
  reg_idx_e                     cfg_idx;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign pready      = 1'b1;

  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[AddrBits-1:2]);

  // register read mux
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      RegRampEnable: prdata = {{(DataBits-1){1'b0}}, ramp_en_q};
      RegRampWindow: prdata = {{(DataBits-WindowBits){1'b0}}, window_q};
      RegRampLimit:  prdata = {{(DataBits-StepBits){1'b0}}, limit_q};
      RegSlot0Max:   prdata = {{(DataBits-ValueBits){1'b0}}, slot_max_q[0]};
      RegSlot1Max:   prdata = {{(DataBits-ValueBits){1'b0}}, slot_max_q[1]};
      RegSlot2Max:   prdata = {{(DataBits-ValueBits){1'b0}}, slot_max_q[2]};
      RegSlot3Max:   prdata = {{(DataBits-ValueBits){1'b0}}, slot_max_q[3]};
      default:       prdata = '0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_en_q <= RampEnableReset;
      window_q  <= RampWindowReset;
      limit_q   <= RampLimitReset;
      for (int i = 0; i < SlotCount; i++) begin
        slot_max_q[i] <= SlotMaxReset[i];
      end
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegRampEnable: ramp_en_q     <= pwdata[0];
        RegRampWindow: window_q      <= pwdata[WindowBits-1:0];
        RegRampLimit:  limit_q       <= pwdata[StepBits-1:0];
        RegSlot0Max:   slot_max_q[0] <= pwdata[ValueBits-1:0];
        RegSlot1Max:   slot_max_q[1] <= pwdata[ValueBits-1:0];
        RegSlot2Max:   slot_max_q[2] <= pwdata[ValueBits-1:0];
        RegSlot3Max:   slot_max_q[3] <= pwdata[ValueBits-1:0];
        default: ;
      endcase
    end
  end

  // setup arithmetic on the held word
  assign slot         = item_q.encoder_slot;
  assign cur_value    = value_q[slot];
  assign slot_max     = slot_max_q[slot];
  assign drag_clamped = (item_q.drag_value > slot_max) ? slot_max : item_q.drag_value;
  assign total        = $signed({{(TotalBits-CpdShift){1'b0}}, resid_q[slot]})
                      + $signed({item_q.count_change[CountBits-1], item_q.count_change});
  // floor division by a power of two
  assign detents      = total >>> CpdShift;
  assign det_mag      = detents[TotalBits-1] ? TotalBits'(-detents) : TotalBits'(detents);
  assign gap          = item_q.now_ms - last_time_q;
  assign restart      = ({1'b0, slot} != last_slot_q)
                      || (gap > {{(TimeBits-WindowBits){1'b0}}, window_q});
  assign step_ext     = $signed({{(AccBits-StepBits){1'b0}}, step_q});
  assign maxv_ext     = $signed({{(AccBits-ValueBits){1'b0}}, maxv_q});

  // sequencer
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    chg_d       = chg_q;
    maxv_d      = maxv_q;
    step_d      = step_q;
    last_slot_d = last_slot_q;
    last_time_d = last_time_q;
    value_we    = 1'b0;
    value_wdata = '0;
    resid_we    = 1'b0;
    resid_wdata = total[CpdShift-1:0];
    out_valid_d = out_valid_q & ~out_ready_i;
    out_word_d  = out_word_q;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          item_d  = in_word_i;
          state_d = StPrep;
        end
      end

      StPrep: begin
        maxv_d  = slot_max;
        neg_d   = detents[TotalBits-1];
        cnt_d   = det_mag[DetMagBits-1:0];
        state_d = StDone;
        if (item_q.drag_active) begin
          // override: residual and ramp untouched
          acc_d = $signed({{(AccBits-ValueBits){1'b0}}, drag_clamped});
          chg_d = (cur_value != drag_clamped);
        end else begin
          resid_we = 1'b1;
          acc_d    = $signed({{(AccBits-ValueBits){1'b0}}, cur_value});
          chg_d    = (detents != '0);
          if (detents != '0) begin
            last_slot_d = {1'b0, slot};
            last_time_d = item_q.now_ms;
            if (!ramp_en_q) begin
              // one unit per detent
              step_d = StepBits'(1);
              acc_d  = $signed({{(AccBits-ValueBits){1'b0}}, cur_value})
                     + AccBits'(detents);
            end else begin
              if (restart) begin
                step_d = StepBits'(1);
              end
              state_d = StRamp;
            end
          end
        end
      end

      // one detent per cycle through the ramp adder
      StRamp: begin
        acc_d = neg_q ? (acc_q - step_ext) : (acc_q + step_ext);
        if (step_q < limit_q) begin
          step_d = step_q + StepBits'(1);
        end
        cnt_d = cnt_q - DetMagBits'(1);
        if (cnt_q == DetMagBits'(1)) begin
          state_d = StDone;
        end
      end

      // clamp, write back, load the output register once it is free
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          value_we = 1'b1;
          if (acc_q < 0) begin
            value_wdata = '0;
            out_word_d.value_changed = 1'b1;
          end else if (acc_q > maxv_ext) begin
            value_wdata = maxv_q;
            out_word_d.value_changed = 1'b1;
          end else begin
            value_wdata = acc_q[ValueBits-1:0];
            out_word_d.value_changed = chg_q;
          end
          out_word_d.out_slot       = slot;
          out_word_d.slot_value_out = value_wdata;
          out_valid_d               = 1'b1;
          state_d                   = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  // control and slot state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      step_q      <= StepBits'(1);
      last_slot_q <= NoSlot;
      last_time_q <= '0;
      for (int i = 0; i < SlotCount; i++) begin
        value_q[i] <= '0;
        resid_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      last_slot_q <= last_slot_d;
      last_time_q <= last_time_d;
      if (value_we) begin
        value_q[slot] <= value_wdata;
      end
      if (resid_we) begin
        resid_q[slot] <= resid_wdata;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    acc_q      <= acc_d;
    cnt_q      <= cnt_d;
    neg_q      <= neg_d;
    chg_q      <= chg_d;
    maxv_q     <= maxv_d;
    out_word_q <= out_word_d;
  end

endmodule

`default_nettype wire

// ----- tb/sv/edra_result_checker.sv -----
// Result checker for the encoder detent ramp accumulator: watches both word
// channels and the APB writes, predicts each result word and compares it.
// Depends on edra_pkg (word types, register map, reset values).
module edra_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  edra_pkg::in_word_t            in_word_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  edra_pkg::out_word_t           out_word_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [edra_pkg::AddrBits-1:0] paddr_i,
  input  logic [edra_pkg::DataBits-1:0] pwdata_i,
  input  logic                          pready_i,
  output int unsigned                   error_count_o,
  output int unsigned                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import edra_pkg::*;

  localparam int DetentCounts = int'(CountsPerDetent);

  // Shadow copy of the configuration registers
  logic                  ramp_on;
  logic [WindowBits-1:0] window_ms;
  logic [StepBits-1:0]   step_limit;
  logic [ValueBits-1:0]  value_max [SlotCount];

  // Predicted block state
  logic [ValueBits-1:0]  value_q    [SlotCount];
  logic [CpdShift-1:0]   residual_q [SlotCount];
  logic [StepBits-1:0]   step_q;
  logic [SlotBits:0]     last_slot_q;
  logic [TimeBits-1:0]   last_time_q;

  out_word_t   expected_words[$];
  int unsigned mismatches;

  // Applies one word to the predicted state and returns its result word
  function automatic out_word_t accumulate_word(in_word_t w);
    int                   total;
    int                   detents;
    int                   mag;
    int                   delta;
    int                   v;
    logic [SlotBits-1:0]  s;
    logic [ValueBits-1:0] pick;
    out_word_t            r;
    s = w.encoder_slot;
    r.out_slot = s;
    r.value_changed = 1'b0;
    if (w.drag_active) begin
      // override: count change dropped, residual and ramp left alone
      pick = (w.drag_value > value_max[s]) ? value_max[s] : w.drag_value;
      if (value_q[s] != pick) begin
        value_q[s] = pick;
        r.value_changed = 1'b1;
      end
    end else begin
      total = int'(residual_q[s]) + int'($signed(w.count_change));
      // floor division, residual stays in 0..3
      if (total >= 0) detents = total / DetentCounts;
      else detents = -((-total + DetentCounts - 1) / DetentCounts);
      residual_q[s] = CpdShift'(total - detents * DetentCounts);
      v = int'(value_q[s]);
      if (detents != 0) begin
        r.value_changed = 1'b1;
        if (!ramp_on) begin
          step_q = 1;
          delta = detents;
        end else begin
          if (last_slot_q != {1'b0, s} ||
              (w.now_ms - last_time_q) > TimeBits'(window_ms)) begin
            step_q = 1;
          end
          mag = (detents > 0) ? detents : -detents;
          delta = 0;
          for (int i = 0; i < mag; i++) begin
            delta += int'(step_q);
            if (step_q < step_limit) step_q = step_q + 1'b1;
          end
          if (detents < 0) delta = -delta;
        end
        last_slot_q = {1'b0, s};
        last_time_q = w.now_ms;
        v += delta;
      end
      // clamp to 0 .. slot max
      if (v < 0) begin
        v = 0;
        r.value_changed = 1'b1;
      end
      if (v > int'(value_max[s])) begin
        v = int'(value_max[s]);
        r.value_changed = 1'b1;
      end
      value_q[s] = ValueBits'(v);
    end
    r.slot_value_out = value_q[s];
    return r;
  endfunction

  task automatic apply_write(logic [AddrBits-1:0] addr, logic [DataBits-1:0] data);
    case (addr[AddrBits-1:2])
      RegRampEnable: ramp_on    = data[0];
      RegRampWindow: window_ms  = data[WindowBits-1:0];
      RegRampLimit:  step_limit = data[StepBits-1:0];
      RegSlot0Max:   value_max[0] = data[ValueBits-1:0];
      RegSlot1Max:   value_max[1] = data[ValueBits-1:0];
      RegSlot2Max:   value_max[2] = data[ValueBits-1:0];
      RegSlot3Max:   value_max[3] = data[ValueBits-1:0];
      default: ;
    endcase
  endtask

  task automatic compare_field(string name, logic [ValueBits-1:0] want,
                               logic [ValueBits-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare result words, queue predictions for taken words, apply APB writes
  always @(posedge clk_i or negedge rst_ni) begin : track
    out_word_t want;
    if (!rst_ni) begin
      ramp_on    = RampEnableReset;
      window_ms  = RampWindowReset;
      step_limit = RampLimitReset;
      for (int i = 0; i < SlotCount; i++) begin
        value_max[i]  = SlotMaxReset[i];
        value_q[i]    = '0;
        residual_q[i] = '0;
      end
      step_q      = 1;
      last_slot_q = NoSlot;
      last_time_q = '0;
      mismatches  = 0;
      expected_words.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word %h with nothing expected", $time, out_word_i);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          compare_field("out_slot", ValueBits'(want.out_slot),
                        ValueBits'(out_word_i.out_slot));
          compare_field("slot_value_out", want.slot_value_out,
                        out_word_i.slot_value_out);
          compare_field("value_changed", ValueBits'(want.value_changed),
                        ValueBits'(out_word_i.value_changed));
        end
      end
      if (in_valid_i && in_ready_i) expected_words.push_back(accumulate_word(in_word_i));
      if (psel_i && penable_i && pwrite_i && pready_i) apply_write(paddr_i, pwdata_i);
    end
    pending_o     <= expected_words.size();
    error_count_o <= mismatches;
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the encoder detent ramp accumulator testbench: clock, reset, APB
// setup, input words, result back-pressure and the final verdict.
// Depends on edra_pkg, encoder_detent_ramp_accumulator and edra_result_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import edra_pkg::*;

  localparam int StuckLimit = 4000;
  localparam int LongHold   = 300;
  localparam int DrainWait  = 40;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  in_word_t            in_word   = '0;
  logic                out_ready = 1'b0;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [AddrBits-1:0] paddr     = '0;
  logic [DataBits-1:0] pwdata    = '0;
  logic                in_ready;
  logic                out_valid;
  out_word_t           out_word;
  logic [DataBits-1:0] prdata;
  logic                pready;
  int unsigned         fail_count;
  int unsigned         pending;
  int unsigned         stuck_cycles = 0;

  // stimulus shaping state
  bit                  steady    = 1'b0;
  bit                  hold_long = 1'b0;
  logic [TimeBits-1:0] clock_ms  = '0;
  int                  window_now = int'(RampWindowReset);
  int                  gesture_left = 0;
  int                  gesture_slot = 0;
  bit                  gesture_down = 1'b0;

  always #2 clk = ~clk;

  encoder_detent_ramp_accumulator u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  edra_result_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_word_i     (in_word),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_word_i    (out_word),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .error_count_o (fail_count),
    .pending_o     (pending)
  );

  // Watchdog: cycles in a row with no word and no register write taken
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Result side: random stall bursts, one long hold, none when steady
  initial begin : result_sink
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_long = 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat (steady ? 1 : $urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  function automatic in_word_t make_word(int slot, int change, logic [TimeBits-1:0] now,
                                         bit drag, int dval);
    in_word_t w;
    w.encoder_slot = SlotBits'(slot);
    w.count_change = CountBits'(change);
    w.now_ms       = now;
    w.drag_active  = drag;
    w.drag_value   = ValueBits'(dval);
    return w;
  endfunction

  // Offers one word, with an optional idle burst before it
  task automatic offer_word(in_word_t w);
    int gap;
    gap = (!steady && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Ends a phase: stop offering and wait for every result word
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [DataBits-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegRampWindow) window_now = int'(value[WindowBits-1:0]);
  endtask

  task automatic load_settings(bit en, int win, int lim, int m0, int m1, int m2, int m3);
    drain();
    write_reg(RegRampEnable, DataBits'(en));
    write_reg(RegRampWindow, DataBits'(win));
    write_reg(RegRampLimit, DataBits'(lim));
    write_reg(RegSlot0Max, DataBits'(m0));
    write_reg(RegSlot1Max, DataBits'(m1));
    write_reg(RegSlot2Max, DataBits'(m2));
    write_reg(RegSlot3Max, DataBits'(m3));
  endtask

  function automatic int pick_max();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 1023;
    return $urandom_range(20, 1023);
  endfunction

  task automatic random_settings();
    int r;
    int win;
    int lim;
    r = $urandom_range(0, 5);
    win = (r == 0) ? 0 : (r == 1) ? 65535 : (r == 2) ? 75 : $urandom_range(5, 300);
    r = $urandom_range(0, 5);
    lim = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 255 : $urandom_range(2, 40);
    load_settings($urandom_range(0, 3) != 0, win, lim,
                  pick_max(), pick_max(), pick_max(), pick_max());
  endtask

  // One random word: mostly turn gestures on one slot, else drag or noise
  task automatic random_word();
    int r;
    int mag;
    int step_ms;
    if (gesture_left == 0 && $urandom_range(0, 99) < 70) begin
      gesture_left = $urandom_range(2, 12);
      gesture_slot = $urandom_range(0, 3);
      gesture_down = $urandom_range(0, 1);
    end
    if (gesture_left != 0) begin
      gesture_left--;
      r = $urandom_range(0, 15);
      if (r == 0) step_ms = window_now + 1;
      else if (r == 1) step_ms = window_now;
      else step_ms = $urandom_range(0, (window_now > 60) ? 60 : window_now);
      clock_ms += TimeBits'(step_ms);
      r = $urandom_range(0, 11);
      if (r == 0) mag = gesture_down ? 128 : 127;
      else mag = $urandom_range(1, 24);
      // an occasional small kick against the turn
      if ($urandom_range(0, 15) == 0) offer_word(make_word(gesture_slot,
          gesture_down ? 2 : -2, clock_ms, 1'b0, 0));
      else offer_word(make_word(gesture_slot, gesture_down ? -mag : mag, clock_ms,
          1'b0, 0));
    end else begin
      if ($urandom_range(0, 1) == 0) clock_ms = $urandom;
      else clock_ms += TimeBits'($urandom_range(0, 500));
      offer_word(make_word($urandom_range(0, 3), $urandom_range(0, 255), clock_ms,
                           $urandom_range(0, 1), $urandom_range(0, 1023)));
    end
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: ramp growth, window edge, slot switch, clamps, drag, wrap
    clock_ms = 32'd1000;
    offer_word(make_word(0, 4, clock_ms, 1'b0, 0));
    clock_ms += 10;
    offer_word(make_word(0, 8, clock_ms, 1'b0, 0));
    clock_ms += 10;
    offer_word(make_word(0, 3, clock_ms, 1'b0, 0));
    clock_ms += 10;
    offer_word(make_word(0, 1, clock_ms, 1'b0, 0));
    clock_ms += 75;
    offer_word(make_word(0, -1, clock_ms, 1'b0, 0));
    clock_ms += 76;
    offer_word(make_word(0, 4, clock_ms, 1'b0, 0));
    offer_word(make_word(1, 127, clock_ms, 1'b0, 0));
    offer_word(make_word(1, -128, clock_ms, 1'b0, 0));
    offer_word(make_word(2, 0, clock_ms, 1'b1, 1023));
    offer_word(make_word(2, 127, clock_ms, 1'b1, 100));
    offer_word(make_word(3, 0, clock_ms, 1'b0, 0));
    clock_ms = 32'hFFFF_FFF0;
    offer_word(make_word(3, 4, clock_ms, 1'b0, 0));
    clock_ms = 32'h0000_0010;
    offer_word(make_word(3, 4, clock_ms, 1'b0, 0));
    offer_word(make_word(3, -128, clock_ms, 1'b0, 0));

    // Ramp off, zero window, full limit, zero and full slot maxima
    load_settings(1'b0, 0, 255, 0, 1023, 1023, 50);
    offer_word(make_word(0, 8, clock_ms, 1'b0, 0));
    offer_word(make_word(1, 127, clock_ms, 1'b0, 0));
    offer_word(make_word(1, 127, clock_ms, 1'b0, 0));
    offer_word(make_word(3, 0, clock_ms, 1'b1, 1000));
    offer_word(make_word(2, -5, clock_ms, 1'b0, 0));

    // Limit of zero keeps the step at one; zero gap still ramps
    load_settings(1'b1, 0, 0, 1023, 1023, 1023, 1023);
    offer_word(make_word(2, 40, clock_ms, 1'b0, 0));
    offer_word(make_word(2, 40, clock_ms, 1'b0, 0));

    // Widest window, step keeps growing from word to word
    load_settings(1'b1, 65535, 255, 1023, 1023, 1023, 1023);
    for (int i = 0; i < 4; i++) begin
      clock_ms += 60000;
      offer_word(make_word(0, 127, clock_ms, 1'b0, 0));
    end

    // Random phases; the receiver holds off once, the tail runs steady
    for (int phase = 0; phase < 5; phase++) begin
      random_settings();
      for (int n = 0; n < 200; n++) begin
        if (phase == 1 && n == 40) hold_long = 1'b1;
        if (phase == 4 && n == 50) steady = 1'b1;
        random_word();
      end
    end

    drain();
    repeat (DrainWait) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
